// ===== rtl/wsfd_pkg.sv =====
`default_nettype none

package wsfd_pkg;

  // storage depth default and fixed field widths
  localparam int unsigned MAX_POINTS_DEF = 128;
  localparam int unsigned VAL_W          = 32;
  localparam int unsigned K_W            = 17;
  localparam int unsigned IDX_W          = 7;
  localparam int unsigned CFG_AW         = 4;
  localparam int unsigned CFG_DW         = 32;

  // squared courant number limit and reset value, q1.16, and the other register resets
  localparam logic [K_W-1:0] K_ONE       = 17'h10000;
  localparam logic [K_W-1:0] COURANT_RST = 17'd16384;
  localparam logic [7:0]     ACTIVE_RST  = 8'd128;
  localparam logic           DRIVEN_RST  = 1'b1;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_COURANT = 2'd0;
  localparam logic [1:0] REG_ACTIVE  = 2'd1;
  localparam logic [1:0] REG_DRIVEN  = 2'd2;

  // opcodes
  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_ADVANCE = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic [1:0]              opcode;
    logic [IDX_W-1:0]        point_index;
    logic signed [VAL_W-1:0] load_value;
    logic signed [VAL_W-1:0] drive_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] read_value;
    logic                    clipped;
  } out_item_t;

  // per-item control handed to the update stage
  typedef struct packed {
    logic [1:0]              op;
    logic [IDX_W-1:0]        idx;
    logic signed [VAL_W-1:0] load_value;
    logic signed [VAL_W-1:0] drive;
    logic                    drv_en;
    logic [K_W-1:0]          k;
  } ctl_t;

endpackage

`default_nettype wire

// ===== rtl/wsfd_cell.sv =====
`default_nettype none

module wsfd_cell import wsfd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    shift_en,
  input  logic signed [VAL_W-1:0] cur_in,
  input  logic signed [VAL_W-1:0] prev_in,
  output logic signed [VAL_W-1:0] cur_out,
  output logic signed [VAL_W-1:0] prev_out
);

  logic signed [VAL_W-1:0] cur_r;
  logic signed [VAL_W-1:0] prev_r;

  // one string point: current and previous displacement
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r  <= '0;
      prev_r <= '0;
    end else if (shift_en) begin
      cur_r  <= cur_in;
      prev_r <= prev_in;
    end
  end

  assign cur_out  = cur_r;
  assign prev_out = prev_r;

endmodule

`default_nettype wire

// ===== rtl/wsfd_update.sv =====
`default_nettype none

module wsfd_update import wsfd_pkg::*; #(
  parameter int unsigned N  = MAX_POINTS_DEF,
  parameter int unsigned SW = $clog2(MAX_POINTS_DEF + 1)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    shift_en,
  input  logic [SW-1:0]           step,
  input  logic [SW-1:0]           n_last,
  input  ctl_t                    ctl,
  input  logic signed [VAL_W-1:0] head_cur,
  input  logic signed [VAL_W-1:0] head_prev,
  input  logic signed [VAL_W-1:0] right_cur,
  output logic signed [VAL_W-1:0] tail_cur,
  output logic signed [VAL_W-1:0] tail_prev,
  output logic                    clip_now,
  output logic                    rd_hit,
  output logic signed [VAL_W-1:0] rd_data
);

  localparam int unsigned CW = (SW > IDX_W) ? SW : IDX_W;

  typedef struct packed {
    logic signed [VAL_W-1:0] cur_keep;
    logic signed [VAL_W-1:0] prev_new;
    logic signed [33:0]      base;
    logic signed [51:0]      prod;
  } pipe_t;

  pipe_t                   pipe_r, pipe_nxt;
  logic                    upd_r, upd_nxt;
  logic signed [VAL_W-1:0] left_r;

  logic                    is_point, adv, at_left, at_right, interior, right_end, idx_hit;
  logic signed [VAL_W-1:0] end_val, u, r;
  logic signed [33:0]      lap;
  logic signed [51:0]      rnd;
  logic signed [35:0]      sum;
  logic                    ovf_hi, ovf_lo;

  // stage 1: boundary forcing, laplacian, multiply by k
  always_comb begin
    is_point  = step < SW'(N);
    adv       = ctl.op == OP_ADVANCE;
    at_left   = step == '0;
    at_right  = step == n_last;
    interior  = !at_left && (step < n_last);
    right_end = step == (n_last - SW'(1));
    idx_hit   = CW'(step) == CW'(ctl.idx);
    end_val   = ctl.drv_en ? ctl.drive : '0;

    if (adv && at_left) begin
      u = '0;
    end else if (adv && at_right) begin
      u = end_val;
    end else begin
      u = head_cur;
    end
    r = (adv && right_end) ? end_val : right_cur;

    lap = $signed({{2{r[VAL_W-1]}}, r}) + $signed({{2{left_r[VAL_W-1]}}, left_r})
        - $signed({u[VAL_W-1], u, 1'b0});

    pipe_nxt.base = $signed({u[VAL_W-1], u, 1'b0})
                  - $signed({{2{head_prev[VAL_W-1]}}, head_prev});
    pipe_nxt.prod = 52'(lap) * 52'($signed({1'b0, ctl.k}));

    pipe_nxt.cur_keep = head_cur;
    pipe_nxt.prev_new = head_prev;
    upd_nxt           = 1'b0;
    if (is_point) begin
      if (ctl.op == OP_LOAD && idx_hit) begin
        pipe_nxt.cur_keep = ctl.load_value;
        pipe_nxt.prev_new = ctl.load_value;
      end else if (adv && (at_left || at_right)) begin
        pipe_nxt.cur_keep = u;
        pipe_nxt.prev_new = u;
      end else if (adv && interior) begin
        pipe_nxt.prev_new = u;
        upd_nxt           = 1'b1;
      end
    end

    rd_hit  = shift_en && ctl.op == OP_READ && is_point && idx_hit;
    rd_data = head_cur;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upd_r <= 1'b0;
    end else if (shift_en) begin
      upd_r <= upd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      pipe_r <= pipe_nxt;
      left_r <= u;
    end
  end

  // stage 2: round half up, add 2u - p, saturate
  always_comb begin
    rnd      = (pipe_r.prod + 52'sd32768) >>> 16;
    sum      = $signed({{2{pipe_r.base[33]}}, pipe_r.base}) + $signed(rnd[35:0]);
    ovf_hi   = sum > 36'sd2147483647;
    ovf_lo   = sum < -36'sd2147483648;
    if (!upd_r) begin
      tail_cur = pipe_r.cur_keep;
    end else if (ovf_hi) begin
      tail_cur = 32'sh7FFFFFFF;
    end else if (ovf_lo) begin
      tail_cur = 32'sh80000000;
    end else begin
      tail_cur = sum[VAL_W-1:0];
    end
    tail_prev = pipe_r.prev_new;
    clip_now  = upd_r && (ovf_hi || ovf_lo);
  end

endmodule

`default_nettype wire

// ===== rtl/wave_string_fd_step_unit.sv =====
// channel  | direction | handshake          | payload
// ---------+-----------+--------------------+-------------------------------------
// in_      | input     | in_valid/in_stall  | in_data: opcode, point_index, values
// out_     | output    | out_valid/out_stall| out_data: read_value, clipped
// cfg_     | input     | apb psel/penable   | courant_sq, active_points, driven
//
// every item (load, advance, read) rotates the ring of MAX_POINTS cells plus the
// one-slot update stage once after the accepting cycle, with the result register
// loaded at the last rotation step; one point passes the update stage per cycle.
// reset clears every cell to zero and loads the register defaults at once.
// a stalled result waits in the output register; a second finished item waits in
// the hold state until the register frees, and no new item is taken meanwhile.
`default_nettype none

module wave_string_fd_step_unit import wsfd_pkg::*; #(
  parameter int unsigned MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // item input
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  // result output
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  // configuration
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam int unsigned N  = MAX_POINTS;
  localparam int unsigned SW = $clog2(N + 1);
  localparam int unsigned CW = (SW > 8) ? SW : 8;

  // configuration registers
  logic [K_W-1:0] courant_r;
  logic [7:0]     active_r;
  logic           driven_r;

  // control state
  state_t          state_r, state_nxt;
  logic [SW-1:0]   step_r;
  logic [SW-1:0]   n_last_r;
  ctl_t            ctl_r;
  logic            clip_acc_r;
  logic signed [VAL_W-1:0] rd_r;
  logic            out_valid_r;
  out_item_t       out_data_r;

  logic            in_xfer, cfg_wr, out_free, last_step, shift_en, out_load;
  logic [CW-1:0]   ap, n_use;
  logic [K_W-1:0]  k_use;

  // ring wiring: cell i takes from cell i+1, the last cell from the update stage
  logic signed [VAL_W-1:0] cur_w  [N];
  logic signed [VAL_W-1:0] prev_w [N];
  logic signed [VAL_W-1:0] tail_cur, tail_prev, rd_data;
  logic                    clip_now, rd_hit;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      courant_r <= COURANT_RST;
      active_r  <= ACTIVE_RST;
      driven_r  <= DRIVEN_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_COURANT: courant_r <= cfg_pwdata[K_W-1:0];
        REG_ACTIVE:  active_r  <= cfg_pwdata[7:0];
        REG_DRIVEN:  driven_r  <= cfg_pwdata[0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_COURANT: cfg_prdata = CFG_DW'(courant_r);
      REG_ACTIVE:  cfg_prdata = CFG_DW'(active_r);
      REG_DRIVEN:  cfg_prdata = CFG_DW'(driven_r);
      default:     cfg_prdata = '0;
    endcase
  end

  // clamp point count to [3, N] and k to 1.0
  always_comb begin
    ap = CW'(active_r);
    if (ap < CW'(3)) begin
      n_use = CW'(3);
    end else if (ap > CW'(N)) begin
      n_use = CW'(N);
    end else begin
      n_use = ap;
    end
    k_use = (courant_r > K_ONE) ? K_ONE : courant_r;
  end

  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign last_step = step_r == SW'(N);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_xfer) state_nxt = ST_RUN;
      ST_RUN: begin
        if (last_step) state_nxt = out_free ? ST_IDLE : ST_HOLD;
      end
      ST_HOLD: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    shift_en = 1'b0;
    in_stall = 1'b1;
    out_load = 1'b0;
    unique case (state_r)
      ST_IDLE: in_stall = 1'b0;
      ST_RUN: begin
        shift_en = 1'b1;
        out_load = last_step && out_free;
      end
      ST_HOLD: out_load = out_free;
      default: in_stall = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // item latch, step counter, read capture and clip accumulation
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r     <= '0;
      clip_acc_r <= 1'b0;
    end else if (in_xfer) begin
      step_r     <= '0;
      clip_acc_r <= 1'b0;
    end else if (shift_en) begin
      if (!last_step) step_r <= step_r + SW'(1);
      clip_acc_r <= clip_acc_r | clip_now;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      ctl_r.op         <= in_data.opcode;
      ctl_r.idx        <= in_data.point_index;
      ctl_r.load_value <= in_data.load_value;
      ctl_r.drive      <= in_data.drive_sample;
      ctl_r.drv_en     <= driven_r;
      ctl_r.k          <= k_use;
      n_last_r         <= SW'(n_use - CW'(1));
      rd_r             <= '0;
    end else if (rd_hit) begin
      rd_r <= rd_data;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.read_value <= rd_r;
      out_data_r.clipped    <= clip_acc_r | clip_now;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // row of point cells
  for (genvar i = 0; i < N; i++) begin : g_cell
    if (i == N - 1) begin : g_tail
      wsfd_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (shift_en),
        .cur_in   (tail_cur),
        .prev_in  (tail_prev),
        .cur_out  (cur_w[i]),
        .prev_out (prev_w[i])
      );
    end else begin : g_mid
      wsfd_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (shift_en),
        .cur_in   (cur_w[i+1]),
        .prev_in  (prev_w[i+1]),
        .cur_out  (cur_w[i]),
        .prev_out (prev_w[i])
      );
    end
  end

  // update stage sits between the head cell and the tail cell
  wsfd_update #(
    .N  (N),
    .SW (SW)
  ) u_update (
    .clk       (clk),
    .rst_n     (rst_n),
    .shift_en  (shift_en),
    .step      (step_r),
    .n_last    (n_last_r),
    .ctl       (ctl_r),
    .head_cur  (cur_w[0]),
    .head_prev (prev_w[0]),
    .right_cur (cur_w[1]),
    .tail_cur  (tail_cur),
    .tail_prev (tail_prev),
    .clip_now  (clip_now),
    .rd_hit    (rd_hit),
    .rd_data   (rd_data)
  );

endmodule

`default_nettype wire

// ===== rtl/wsfd_chk.sv =====
`default_nettype none

module wsfd_chk import wsfd_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // reset leaves the block empty and ready
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not empty after reset");

  // an accepted item keeps the block busy
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("new item taken while one is in flight");

  // only an advance clips, and an advance reads zero
  a_clip_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.clipped && out_data.read_value != '0))
    else $error("clip flag on a read result");

endmodule

bind wave_string_fd_step_unit wsfd_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import wsfd_pkg::*;

  // directed rows are either an item transfer or a register write
  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_t;

  typedef struct packed {
    row_kind_t  kind;
    in_item_t   item;
    logic       typed;     // expectation typed into the row instead of predicted
    out_item_t  want;
    logic [1:0] reg_idx;
    logic [31:0] reg_val;
  } stim_row_t;

  localparam int unsigned HOLD_CYCLES = 700;
  localparam longint      SAT_HI      = 64'sd2147483647;
  localparam longint      SAT_LO      = -64'sd2147483648;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  in_item_t          in_data;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_item_t         out_data;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  // shadow of the string and of the registers, advanced at each accepted transfer
  logic signed [VAL_W-1:0] prev_disp [MAX_POINTS_DEF];
  logic signed [VAL_W-1:0] cur_disp  [MAX_POINTS_DEF];
  logic [K_W-1:0]          k_q16;
  logic [7:0]              pts_cfg;
  logic                    drive_en;

  out_item_t   pending_results [$];
  stim_row_t   dir_rows [$];
  out_item_t   oldest_want;
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned idle_pct   = 0;
  int unsigned stall_pct  = 0;

  // long receiver hold-off: main flow bumps the request count, stall process runs it
  int unsigned hold_req  = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  wave_string_fd_step_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("[wave_string_fd_step_unit] ERROR");
    $finish;
  end

  // points in use, with the low and high clamp applied
  function automatic int unsigned used_points();
    if (pts_cfg < 3) return 3;
    if (pts_cfg > MAX_POINTS_DEF) return MAX_POINTS_DEF;
    return pts_cfg;
  endfunction

  // one item through the shadow string, returns the result it should produce
  function automatic out_item_t step_wave(input in_item_t it);
    out_item_t               res;
    logic signed [VAL_W-1:0] nxt [MAX_POINTS_DEF];
    int unsigned             n;
    int unsigned             j;
    longint                  kk;
    longint                  u;
    longint                  lap;
    longint                  v;
    res = '0;
    case (it.opcode)
      OP_LOAD: begin
        // same value in both lines: the point starts at rest
        prev_disp[it.point_index] = it.load_value;
        cur_disp[it.point_index]  = it.load_value;
      end
      OP_ADVANCE: begin
        n = used_points();
        if (k_q16 > K_ONE) kk = 65536;
        else kk = k_q16;
        // pin both ends before the interior update
        cur_disp[0]   = '0;
        cur_disp[n-1] = drive_en ? it.drive_sample : '0;
        nxt = cur_disp;
        for (j = 1; j + 1 < n; j++) begin
          u   = cur_disp[j];
          lap = longint'(cur_disp[j+1]) + longint'(cur_disp[j-1]) - 2 * u;
          // q8.40 product rounded half up back to q8.24
          v   = 2 * u - longint'(prev_disp[j]) + ((lap * kk + 64'sd32768) >>> 16);
          if (v > SAT_HI) begin
            v = SAT_HI;
            res.clipped = 1'b1;
          end else if (v < SAT_LO) begin
            v = SAT_LO;
            res.clipped = 1'b1;
          end
          nxt[j] = v[31:0];
        end
        // rotate only the active part, points past the end stay put
        for (j = 0; j < n; j++) begin
          prev_disp[j] = cur_disp[j];
          cur_disp[j]  = nxt[j];
        end
      end
      OP_READ: res.read_value = cur_disp[it.point_index];
      default: ;
    endcase
    return res;
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3:    return $urandom;
      // most values well below full scale so the string rings without clipping
      default: return $signed($urandom) >>> 6;
    endcase
  endfunction

  task automatic note_error(input string what, input out_item_t want, input out_item_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch (%s): expected read_value %h clipped %0b, got read_value %h clipped %0b",
               what, want.read_value, want.clipped, got.read_value, got.clipped);
  endtask

  task automatic add_item(input logic [1:0] op, input logic [6:0] idx, input logic [31:0] load,
                          input logic [31:0] drive, input logic typed, input logic [31:0] rd,
                          input logic clip);
    stim_row_t row;
    row = '0;
    row.kind              = ROW_ITEM;
    row.item.opcode       = op;
    row.item.point_index  = idx;
    row.item.load_value   = load;
    row.item.drive_sample = drive;
    row.typed             = typed;
    row.want.read_value   = rd;
    row.want.clipped      = clip;
    dir_rows.push_back(row);
  endtask

  task automatic add_cfg(input logic [1:0] idx, input logic [31:0] val);
    stim_row_t row;
    row = '0;
    row.kind    = ROW_CFG;
    row.reg_idx = idx;
    row.reg_val = val;
    dir_rows.push_back(row);
  endtask

  // present one item, hold it until the transfer, then book its expected result
  task automatic offer(input in_item_t item, input logic typed, input out_item_t want);
    out_item_t model_out;
    // now and then a long gap so that offers land at any point of an item's rotation pass
    if (idle_pct != 0 && $urandom_range(7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 260)) @(posedge clk);
    end
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    model_out = step_wave(item);
    pending_results.push_back(typed ? want : model_out);
    items_sent++;
  endtask

  // valid drops in the step of the last transfer, then wait for every result
  task automatic wait_string_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // apb write: setup cycle, then access until pready
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_COURANT: k_q16    = val[K_W-1:0];
      REG_ACTIVE:  pts_cfg  = val[7:0];
      REG_DRIVEN:  drive_en = val[0];
      default: ;
    endcase
  endtask

  task automatic setup_phase(input logic [31:0] k, input logic [31:0] pts, input logic drv,
                             input int unsigned idle, input int unsigned stall);
    wait_string_idle();
    write_reg(REG_COURANT, k);
    write_reg(REG_ACTIVE, pts);
    write_reg(REG_DRIVEN, {31'd0, drv});
    idle_pct  = idle;
    stall_pct = stall;
  endtask

  // mostly plucks: a few loaded points, some steps, then samples; the rest is noise
  task automatic run_random(input int unsigned n_items);
    int unsigned start;
    int unsigned span;
    in_item_t    it;
    start = items_sent;
    while (items_sent - start < n_items) begin
      span = used_points();
      if ($urandom_range(3) != 0) begin
        repeat ($urandom_range(1, 4)) begin
          it             = '0;
          it.opcode      = OP_LOAD;
          it.point_index = 7'($urandom_range(span - 1));
          it.load_value  = pick_value();
          offer(it, 1'b0, '0);
        end
        repeat ($urandom_range(1, 4)) begin
          it              = '0;
          it.opcode       = OP_ADVANCE;
          it.point_index  = 7'($urandom);
          it.drive_sample = pick_value();
          offer(it, 1'b0, '0);
        end
        repeat ($urandom_range(1, 4)) begin
          it             = '0;
          it.opcode      = OP_READ;
          // occasionally sample past the active end
          it.point_index = 7'(($urandom_range(4) == 0) ? $urandom : $urandom_range(span - 1));
          offer(it, 1'b0, '0);
        end
      end else begin
        repeat ($urandom_range(1, 4)) begin
          it = in_item_t'({$urandom, $urandom, $urandom});
          offer(it, 1'b0, '0);
        end
      end
    end
  endtask

  // receiver side: random stall, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // every result transfer is checked against the oldest booked expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        note_error("result with nothing expected", '0, out_data);
      end else begin
        oldest_want = pending_results.pop_front();
        if (out_data.read_value !== oldest_want.read_value)
          note_error("read_value", oldest_want, out_data);
        if (out_data.clipped !== oldest_want.clipped)
          note_error("clipped", oldest_want, out_data);
      end
    end
  end

  initial begin
    in_valid    <= 1'b0;
    in_data     <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    rst_n       <= 1'b0;
    foreach (cur_disp[i]) begin
      cur_disp[i]  = '0;
      prev_disp[i] = '0;
    end
    k_q16    = COURANT_RST;
    pts_cfg  = ACTIVE_RST;
    drive_en = DRIVEN_RST;

    // reset defaults: k 0.25, all 128 points, right end driven
    add_item(OP_READ,    7'd0,   32'h0,         32'h0,         1, 32'h0,         0);
    add_item(OP_READ,    7'd127, 32'h0,         32'h0,         1, 32'h0,         0);
    // unused opcode with every payload bit set does nothing
    add_item(2'd3,       7'd127, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'h0,         0);
    add_item(OP_LOAD,    7'd64,  32'h7FFF_FFFF, 32'h0,         1, 32'h0,         0);
    add_item(OP_LOAD,    7'd65,  32'h8000_0000, 32'h0,         1, 32'h0,         0);
    add_item(OP_READ,    7'd64,  32'h0,         32'h0,         1, 32'h7FFF_FFFF, 0);
    add_item(OP_READ,    7'd65,  32'h0,         32'h0,         1, 32'h8000_0000, 0);
    add_item(OP_LOAD,    7'd127, 32'h0100_0000, 32'h0,         1, 32'h0,         0);
    add_item(OP_READ,    7'd127, 32'h0,         32'h0,         1, 32'h0100_0000, 0);
    add_item(OP_ADVANCE, 7'd0,   32'h0,         32'h7FFF_FFFF, 0, 32'h0,         0);
    // driven right end keeps the forced sample, left end stays at zero
    add_item(OP_READ,    7'd127, 32'h0,         32'h0,         1, 32'h7FFF_FFFF, 0);
    add_item(OP_READ,    7'd0,   32'h0,         32'h0,         1, 32'h0,         0);
    add_item(OP_READ,    7'd64,  32'h0,         32'h0,         0, 32'h0,         0);
    add_item(OP_ADVANCE, 7'd0,   32'h0,         32'h8000_0000, 0, 32'h0,         0);
    add_item(OP_READ,    7'd127, 32'h0,         32'h0,         1, 32'h8000_0000, 0);
    // k above one is used as one, fewer than three points as three, right end held
    add_cfg(REG_COURANT, 32'h0001_FFFF);
    add_cfg(REG_ACTIVE,  32'd0);
    add_cfg(REG_DRIVEN,  32'd0);
    add_item(OP_LOAD,    7'd1,   32'h8000_0000, 32'h0,         1, 32'h0,         0);
    // point at rest at full negative scale with k of one overshoots to +2^31: clips
    add_item(OP_ADVANCE, 7'd0,   32'h0,         32'h1234_5678, 1, 32'h0,         1);
    add_item(OP_READ,    7'd1,   32'h0,         32'h0,         1, 32'h7FFF_FFFF, 0);
    add_item(OP_READ,    7'd2,   32'h0,         32'h0,         1, 32'h0,         0);
    // a point past the active end is left alone by the step
    add_item(OP_LOAD,    7'd100, 32'h00AB_CDEF, 32'h0,         1, 32'h0,         0);
    add_item(OP_ADVANCE, 7'd0,   32'h0,         32'h1234_5678, 0, 32'h0,         0);
    add_item(OP_READ,    7'd100, 32'h0,         32'h0,         1, 32'h00AB_CDEF, 0);
    add_item(OP_READ,    7'd1,   32'h0,         32'h0,         0, 32'h0,         0);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_CFG) begin
        wait_string_idle();
        write_reg(dir_rows[r].reg_idx, dir_rows[r].reg_val);
      end else begin
        offer(dir_rows[r].item, dir_rows[r].typed, dir_rows[r].want);
      end
    end

    // back to back, k of exactly one, full length, driven end
    setup_phase(32'h0001_0000, 32'd128, 1'b1, 0, 0);
    run_random(30);
    // receiver holds off while offers keep coming, so the block backs up
    hold_req++;
    run_random(30);
    // sender waits for the string to empty out
    wait_string_idle();
    run_random(40);

    // sparse sender, random k, short string, right end pinned
    setup_phase($urandom_range(0, 65536), 32'd16, 1'b0, 86, 0);
    run_random(100);

    // heavy receiver stall, k of zero, length above storage clamps to storage
    setup_phase(32'd0, 32'd255, 1'b1, 0, 86);
    run_random(100);

    // light idling on both sides, every register random over its full field
    setup_phase($urandom_range(0, 131071), $urandom_range(0, 255), 1'($urandom_range(1)), 6, 6);
    run_random(100);

    // let any stray result show up before the verdict
    wait_string_idle();
    repeat (140) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("[wave_string_fd_step_unit] OK");
    end else begin
      $display("[wave_string_fd_step_unit] ERROR");
    end
    $finish;
  end

endmodule
